/* src/cpl_pkg.sv */
`timescale 1ns / 1ps

package cpl_pkg;

    localparam int COORD_BITS  = 24;
    localparam int LENGTH_BITS = 40;

    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int RT_W  = COORD_BITS + 1;
    localparam int RAD_W = 2 * RT_W;
    localparam int REM_W = RT_W + 3;
    localparam int CNT_W = $clog2(RT_W);

    typedef struct packed {
        logic                          first_point;
        logic signed [COORD_BITS-1:0]  pos_x;
        logic signed [COORD_BITS-1:0]  pos_y;
    } t_in_item;

    typedef struct packed {
        logic [LENGTH_BITS-1:0] path_length;
        logic                   saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load;
        logic sq_x;
        logic sq_y;
        logic root_step;
        logic acc;
    } t_dp_cmd;

    typedef struct packed {
        logic first;
        logic root_last;
    } t_dp_sts;

endpackage

/* src/cpl_dp.sv */
`timescale 1ns / 1ps

module cpl_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cpl_pkg::t_in_item i_data,
    input  cpl_pkg::t_dp_cmd  i_cmd,
    output cpl_pkg::t_dp_sts  o_sts,
    output cpl_pkg::t_out_item o_data
);

    localparam int C     = cpl_pkg::COORD_BITS;
    localparam int L     = cpl_pkg::LENGTH_BITS;
    localparam int SQ_W  = cpl_pkg::SQ_W;
    localparam int RT_W  = cpl_pkg::RT_W;
    localparam int RAD_W = cpl_pkg::RAD_W;
    localparam int REM_W = cpl_pkg::REM_W;
    localparam int CNT_W = cpl_pkg::CNT_W;

    logic [C-1:0]       r_last_x, r_last_y;
    logic [C-1:0]       r_dx, r_dy, r_absx;
    logic               r_first;
    logic [SQ_W:0]      r_sq;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [RT_W-1:0]    r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic [L-1:0]       r_running;
    cpl_pkg::t_out_item r_out;

    logic [C:0]       diff_x, diff_y, abs_x_ext;
    logic [C-1:0]     mul_a;
    logic [SQ_W-1:0]  prod;
    logic [REM_W-1:0] rem_sh, trial;
    logic [L:0]       sum_len;
    logic [L-1:0]     n_len;

    // signed differences against the stored waypoint
    assign diff_x = {i_data.pos_x[C-1], i_data.pos_x} - {r_last_x[C-1], r_last_x};
    assign diff_y = {i_data.pos_y[C-1], i_data.pos_y} - {r_last_y[C-1], r_last_y};
    assign abs_x_ext = i_data.pos_x[C-1] ? -{i_data.pos_x[C-1], i_data.pos_x}
                                         : {i_data.pos_x[C-1], i_data.pos_x};

    assign mul_a = i_cmd.sq_y ? r_dy : r_dx;
    assign prod  = SQ_W'(mul_a) * SQ_W'(mul_a);

    // one root bit per step
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});

    always_comb begin
        if (r_first) begin
            sum_len = (L+1)'(r_absx);
        end else begin
            sum_len = {1'b0, r_running} + (L+1)'(r_root);
        end
        n_len = sum_len[L] ? {L{1'b1}} : sum_len[L-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_running <= '0;
        end else begin
            if (i_cmd.load) begin
                r_first  <= i_data.first_point;
                r_dx     <= diff_x[C] ? C'(-diff_x) : diff_x[C-1:0];
                r_dy     <= diff_y[C] ? C'(-diff_y) : diff_y[C-1:0];
                r_absx   <= abs_x_ext[C-1:0];
                r_last_x <= i_data.pos_x;
                r_last_y <= i_data.pos_y;
            end
            if (i_cmd.sq_x) begin
                r_sq <= {1'b0, prod};
            end
            if (i_cmd.sq_y) begin
                r_rad  <= RAD_W'(r_sq + {1'b0, prod});
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            if (i_cmd.root_step) begin
                r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[RT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[RT_W-2:0], 1'b0};
                end
            end
            if (i_cmd.acc) begin
                r_running         <= n_len;
                r_out.path_length <= n_len;
                r_out.saturated   <= (n_len == {L{1'b1}});
            end
        end
    end

    assign o_sts.first     = r_first;
    assign o_sts.root_last = (r_cnt == CNT_W'(RT_W - 1));
    assign o_data          = r_out;

endmodule

/* src/cpl_ctrl.sv */
`timescale 1ns / 1ps

module cpl_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  cpl_pkg::t_dp_sts i_sts,
    output cpl_pkg::t_dp_cmd o_cmd
);

    cpl_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            out_free;

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            cpl_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = cpl_pkg::ST_SQ_X;
                end
            end
            cpl_pkg::ST_SQ_X: begin
                n_state = i_sts.first ? cpl_pkg::ST_ACC : cpl_pkg::ST_SQ_Y;
            end
            cpl_pkg::ST_SQ_Y: begin
                n_state = cpl_pkg::ST_ROOT;
            end
            cpl_pkg::ST_ROOT: begin
                if (i_sts.root_last) begin
                    n_state = cpl_pkg::ST_ACC;
                end
            end
            cpl_pkg::ST_ACC: begin
                if (out_free) begin
                    n_state = cpl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cpl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            cpl_pkg::ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            cpl_pkg::ST_SQ_X: begin
                o_cmd.sq_x = !i_sts.first;
            end
            cpl_pkg::ST_SQ_Y: begin
                o_cmd.sq_y = 1'b1;
            end
            cpl_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
            end
            cpl_pkg::ST_ACC: begin
                o_cmd.acc = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign n_out_valid = o_cmd.acc | (r_out_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    a_acc_never_overwrites: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |-> (!r_out_valid || !i_stall))
        else $error("result register overwritten while held");

    a_acc_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.acc |=> r_out_valid)
        else $error("result not presented after accumulate");

    a_root_ends_in_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpl_pkg::ST_ROOT && i_sts.root_last) |=> r_state == cpl_pkg::ST_ACC)
        else $error("root iteration did not end in accumulate");

    a_sq_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == cpl_pkg::ST_SQ_X)
        else $error("accepted item not dispatched");

endmodule

/* src/cumulative_path_length_core.sv */
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_data  (cpl_pkg::t_in_item)
// result    out        o_valid / i_stall      o_data  (cpl_pkg::t_out_item)
//
// one item at a time: a first point passes from accept through ST_SQ_X to ST_ACC,
// any other point through ST_SQ_X, ST_SQ_Y and ST_ROOT, where the bit-serial
// square root gives one root bit per cycle, to ST_ACC, which registers the result
// an item holds the core until ST_ACC registers its result, input stalled meanwhile
// synchronous active-low reset clears the controller, result valid, last point and length
// a new item is taken while the previous result waits under i_stall

module cumulative_path_length_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cpl_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output cpl_pkg::t_out_item  o_data
);

    cpl_pkg::t_dp_cmd cmd;
    cpl_pkg::t_dp_sts sts;

    cpl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cpl_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_data  (o_data)
    );

endmodule

/* bench/path_length_check.sv */
`timescale 1ns / 1ps

module path_length_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  cpl_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  cpl_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_sat_seen
);

    localparam int COORD_BITS  = cpl_pkg::COORD_BITS;
    localparam int LENGTH_BITS = cpl_pkg::LENGTH_BITS;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;
    logic [LENGTH_BITS-1:0]       length_acc;
    cpl_pkg::t_out_item           expected_lengths[$];
    cpl_pkg::t_out_item           want;

    function automatic cpl_pkg::t_out_item walk_to(cpl_pkg::t_in_item wp);
        logic signed [COORD_BITS:0] ex;
        logic signed [COORD_BITS:0] ey;
        logic [COORD_BITS:0]        dx;
        logic [COORD_BITS:0]        dy;
        logic [63:0]                sum_sq;
        logic [63:0]                trial;
        logic [63:0]                root;
        logic [LENGTH_BITS:0]       total;
        cpl_pkg::t_out_item         res;
        if (wp.first_point) begin
            ex = (COORD_BITS+1)'(wp.pos_x);
            if (ex < 0) ex = -ex;
            dx = ex;
            total = (LENGTH_BITS+1)'(dx);
        end else begin
            ex = (COORD_BITS+1)'(wp.pos_x) - (COORD_BITS+1)'(prev_x);
            ey = (COORD_BITS+1)'(wp.pos_y) - (COORD_BITS+1)'(prev_y);
            if (ex < 0) ex = -ex;
            if (ey < 0) ey = -ey;
            dx = ex;
            dy = ey;
            sum_sq = 64'(dx) * 64'(dx) + 64'(dy) * 64'(dy);
            // floored root, one bit at a time from the top
            root = '0;
            for (int b = COORD_BITS; b >= 0; b--) begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sum_sq) root = trial;
            end
            total = {1'b0, length_acc} + root[LENGTH_BITS:0];
        end
        if (total > {1'b0, LEN_MAX}) total = {1'b0, LEN_MAX};
        length_acc = total[LENGTH_BITS-1:0];
        prev_x = wp.pos_x;
        prev_y = wp.pos_y;
        res.path_length = length_acc;
        res.saturated = (length_acc == LEN_MAX);
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            prev_x = '0;
            prev_y = '0;
            length_acc = '0;
            expected_lengths.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_lengths.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected item, expected none, got length %0d saturated %0b",
                             $time, i_out_data.path_length, i_out_data.saturated);
                end else begin
                    want = expected_lengths.pop_front();
                    o_checked++;
                    if (i_out_data.saturated) o_sat_seen++;
                    if (i_out_data.path_length !== want.path_length) begin
                        o_fail_count++;
                        $display("%0t: path_length expected %0d got %0d",
                                 $time, want.path_length, i_out_data.path_length);
                    end
                    if (i_out_data.saturated !== want.saturated) begin
                        o_fail_count++;
                        $display("%0t: saturated expected %0b got %0b",
                                 $time, want.saturated, i_out_data.saturated);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) expected_lengths.push_back(walk_to(i_in_data));
        end
        o_pending = expected_lengths.size();
    end

endmodule

/* bench/cumulative_path_length_core_tb.sv */
`timescale 1ns / 1ps

module cumulative_path_length_core_tb;

    localparam int COORD_BITS  = cpl_pkg::COORD_BITS;
    localparam int WAYPOINTS   = 1700;
    localparam int HOLD_CYCLES = 400;
    localparam int ZIGZAG      = 64;
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    cpl_pkg::t_in_item  i_data;
    logic               o_valid;
    logic               i_stall;
    cpl_pkg::t_out_item o_data;

    logic calm;
    logic hold_req;
    int   fail_count;
    int   pending;
    int   checked;
    int   sat_seen;
    int   sent;

    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;

    cumulative_path_length_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    path_length_check u_path_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_data    (i_data),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_data   (o_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_sat_seen   (sat_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_waypoint(input logic first, input logic signed [COORD_BITS-1:0] x,
                                 input logic signed [COORD_BITS-1:0] y);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len();
        repeat (gap) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{first_point: first, pos_x: x, pos_y: y};
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        px = x;
        py = y;
        sent++;
    endtask

    // result side stalls
    initial begin
        int   run_left;
        logic stall_now;
        i_stall = 1'b0;
        run_left = 0;
        stall_now = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                run_left = 0;
            end
            if (run_left == 0) begin
                stall_now = !calm && $urandom_range(0, 3) == 0;
                run_left = stall_now ? idle_len() : $urandom_range(1, 20);
            end
            run_left--;
            i_stall <= stall_now;
        end
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic                         first;
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        int                           r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        sent = 0;
        px = '0;
        py = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // no first point yet: measured from the origin
        send_waypoint(1'b0, 24'sd12288, 24'sd16384);
        send_waypoint(1'b0, 24'sd12288, 24'sd16384);
        send_waypoint(1'b0, 24'sd12289, 24'sd16384);
        send_waypoint(1'b1, C_MIN, C_MAX);
        send_waypoint(1'b0, C_MAX, C_MIN);
        send_waypoint(1'b1, C_MAX, C_MIN);
        send_waypoint(1'b1, '0, '0);
        send_waypoint(1'b0, '0, C_MAX);
        send_waypoint(1'b0, '0, C_MIN);
        send_waypoint(1'b0, C_MIN, C_MIN);
        send_waypoint(1'b1, -24'sd1, 24'sd5);
        send_waypoint(1'b0, 24'sd1, -24'sd1);
        send_waypoint(1'b0, -24'sd5, 24'sd7);
        send_waypoint(1'b1, -24'sd4096, '0);
        send_waypoint(1'b0, C_MAX, C_MAX);
        send_waypoint(1'b0, C_MIN, C_MIN);
        send_waypoint(1'b0, -24'sd2, C_MAX);
        send_waypoint(1'b1, C_MIN, C_MIN);

        // zig-zag between opposite corners, longest possible steps
        calm = 1'b1;
        for (int k = 0; k < ZIGZAG; k++)
            send_waypoint(1'b0, k[0] ? C_MIN : C_MAX, k[0] ? C_MIN : C_MAX);
        send_waypoint(1'b0, C_MIN, C_MIN);
        send_waypoint(1'b1, -24'sd7, 24'sd3);
        send_waypoint(1'b0, 24'sd100, -24'sd300);
        calm = 1'b0;

        for (int n = 0; n < WAYPOINTS; n++) begin
            calm = (n % 250) >= 200;
            if (n == WAYPOINTS / 2) hold_req = 1'b1;
            first = $urandom_range(0, 9) == 0;
            r = $urandom_range(0, 99);
            if (r < 45) begin
                x = COORD_BITS'($urandom);
                y = COORD_BITS'($urandom);
            end else if (r < 85) begin
                x = px + COORD_BITS'($urandom_range(0, 8191) - 4096);
                y = py + COORD_BITS'($urandom_range(0, 8191) - 4096);
            end else begin
                case ($urandom_range(0, 3))
                    0: x = C_MIN;
                    1: x = C_MAX;
                    2: x = '0;
                    default: x = '1;
                endcase
                case ($urandom_range(0, 3))
                    0: y = C_MIN;
                    1: y = C_MAX;
                    2: y = '0;
                    default: y = '1;
                endcase
            end
            send_waypoint(first, x, y);
        end

        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        $display("sent %0d waypoints (directed, corner zig-zag, random paths)",
                 sent);
        $display("compared %0d lengths, %0d of them at the saturation limit", checked, sat_seen);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
